### rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg - shared types and constants for the first-fit block allocator
// Header format, request/status codes, sequencer states and result record.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int WORD_BYTES     = 8;
    localparam int WORD_SHIFT     = $clog2(WORD_BYTES);
    localparam int POOL_WORDS_DEF = 1024;

    localparam int HDR_W  = 16;                         // signed byte size per header
    localparam int MAG_W  = HDR_W + 1 - WORD_SHIFT;     // |hdr| in words
    localparam int SIZE_W = 16;
    localparam int OFF_W  = 14;
    localparam int CFG_W  = 14;
    localparam int NWD_W  = SIZE_W + 1 - WORD_SHIFT;    // rounded request in words
    localparam int NEED_W = NWD_W + WORD_SHIFT;         // rounded request in bytes
    localparam int CMP_W  = NEED_W + 1;                 // signed compare width

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FIT    = 2'd1,
        STAT_NULL_FREE = 2'd2,
        STAT_NO_POOL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_HEAD,
        ST_BUILD_END,
        ST_WALK_CUR,
        ST_WALK_MERGE,
        ST_SPLIT,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic at_end;   // block ends the walk
        logic is_free;  // header positive
    } hdr_flags_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   alloc_offset;
        logic [OFF_W-1:0]   largest_bytes;
    } res_t;

endpackage

### rtl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit - first-fit allocator over a header pool
// Allocate, free and largest-free query on a pool of word-aligned blocks.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                            | contents
//  ---------+-----+------------------------------------+---------------------------
//  s_       | in  | s_tvalid s_tready s_tdata s_tuser  | request
//  m_       | out | m_tvalid m_tready m_tdata m_tuser  | response
//  cfg_     | in  | cfg_wr_en cfg_wr_data              | pool size in bytes
//
//  Allocate and query walk the headers through one read port, merging each free
//  block with the free blocks after it; a split writes the remainder header before
//  the answer. Free reads one header and writes it back. Writing the pool size
//  lays down the first and last header. After reset the pool is unbuilt, and
//  allocate, query and non-null free requests answer status 3 until configured.
//  A response waits in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit
    import ffa_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF   // 3 .. 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,     // size_bytes[15:0], block_offset[29:16]
    input  logic [1:0]         s_tuser,     // req_type[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,     // alloc_offset[13:0], largest_bytes[27:14]
    output logic [1:0]         m_tuser,     // status[1:0]
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    logic   res_valid, res_ready;
    res_t   res;
    logic   m_tvalid_reg;
    res_t   out_reg;

    ffa_walker #(.POOL_WORDS(POOL_WORDS)) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_type     (req_t'(s_tuser)),
        .size_bytes   (s_tdata[SIZE_W-1:0]),
        .block_offset (s_tdata[SIZE_W+OFF_W-1:SIZE_W]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{(32 - 2 * OFF_W){1'b0}}, out_reg.largest_bytes, out_reg.alloc_offset};

`ifndef NO_ASSERTIONS
    // every accepted request leaves the idle state
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken twice in a row");

    // a finished response never coexists with an open request slot
    a_done_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && s_tready))
        else $error("response pending while ready");

    // a grant carries OK status and no query data
    a_grant_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OFF_W-1:0] != '0) |->
            (m_tuser == STAT_OK) && (m_tdata[2*OFF_W-1:OFF_W] == '0))
        else $error("grant with bad status or size");
`endif

endmodule

### rtl/ffa_hdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_hdr_ram - block header store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_hdr_ram
    import ffa_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(POOL_WORDS)-1:0]     wr_addr,
    input  logic signed [HDR_W-1:0]           wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(POOL_WORDS)-1:0]     rd_addr,
    output logic signed [HDR_W-1:0]           rd_data
);

    logic signed [HDR_W-1:0] mem [POOL_WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/ffa_hdr_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_hdr_eval - header evaluation unit
// Next-block index and end-of-walk test for one header just read.
// ----------------------------------------------------------------------------
module ffa_hdr_eval
    import ffa_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF
) (
    input  logic [$clog2(POOL_WORDS)-1:0]     addr,
    input  logic signed [HDR_W-1:0]           hdr,
    input  logic [$clog2(POOL_WORDS)-1:0]     end_word,
    output logic [((($clog2(POOL_WORDS)) > MAG_W) ? $clog2(POOL_WORDS) : MAG_W):0] nxt,
    output hdr_flags_t                        flags
);

    localparam int AW    = $clog2(POOL_WORDS);
    localparam int NXT_W = ((AW > MAG_W) ? AW : MAG_W) + 1;

    logic [HDR_W:0]   mag;
    logic [MAG_W-1:0] mag_words;

    always_comb begin
        mag       = hdr[HDR_W-1] ? (HDR_W+1)'(-(HDR_W+1)'(hdr)) : (HDR_W+1)'(hdr);
        mag_words = MAG_W'(mag >> WORD_SHIFT);
        nxt       = NXT_W'(addr) + NXT_W'(1) + NXT_W'(mag_words);
        flags.is_free = (hdr > 0);
        flags.at_end  = (addr >= end_word) || (hdr == '0) || (nxt > NXT_W'(end_word));
    end

endmodule

### rtl/ffa_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_walker - allocator sequencer
// Builds the pool, walks and merges block headers, grants, frees, queries.
// ----------------------------------------------------------------------------
module ffa_walker
    import ffa_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_t                req_type,
    input  logic [SIZE_W-1:0]   size_bytes,
    input  logic [OFF_W-1:0]    block_offset,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res
);

    localparam int AW    = $clog2(POOL_WORDS);
    localparam int NXT_W = ((AW > MAG_W) ? AW : MAG_W) + 1;
    localparam int OWD_W = OFF_W - WORD_SHIFT;

    state_t                  state_reg, state_next;
    logic                    ready_reg, ready_next;
    logic [AW-1:0]           end_word_reg, end_word_next;
    req_t                    op_reg, op_next;
    logic [NWD_W-1:0]        need_words_reg, need_words_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic signed [HDR_W-1:0] total_reg, total_next;
    logic [OFF_W-1:0]        largest_reg, largest_next;
    res_t                    res_reg, res_next;
    logic [AW-1:0]           data_addr_reg;
    logic [AW-1:0]           split_addr_reg, split_addr_next;
    logic signed [HDR_W-1:0] split_val_reg, split_val_next;

    logic                    rd_en, wr_en;
    logic [AW-1:0]           rd_addr, wr_addr;
    logic signed [HDR_W-1:0] wr_data, rd_data;
    logic [NXT_W-1:0]        nxt;
    hdr_flags_t              flags;

    // decisions shared by the next-state and datapath blocks
    logic                    accept, cfg_small;
    logic [31:0]             cfg_words, cfg_words_sat;
    logic [OWD_W-1:0]        off_words;
    logic                    free_in_pool;
    logic [NEED_W-1:0]       need;
    logic signed [CMP_W-1:0] total_ext, need_ext;
    logic                    fits, do_split, merge_more;

    ffa_hdr_ram #(.POOL_WORDS(POOL_WORDS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffa_hdr_eval #(.POOL_WORDS(POOL_WORDS)) u_eval (
        .addr     (data_addr_reg),
        .hdr      (rd_data),
        .end_word (end_word_reg),
        .nxt      (nxt),
        .flags    (flags)
    );

    assign req_ready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign accept    = req_valid && req_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    assign cfg_words     = 32'(cfg_wr_data) >> WORD_SHIFT;
    assign cfg_words_sat = (cfg_words > 32'(POOL_WORDS)) ? 32'(POOL_WORDS) : cfg_words;
    assign cfg_small     = 32'(cfg_wr_data) < 32'(3 * WORD_BYTES);

    assign off_words    = OWD_W'(block_offset >> WORD_SHIFT);
    assign free_in_pool = (block_offset[WORD_SHIFT-1:0] == '0)
                       && ((32'(off_words) - 32'd1) < 32'(end_word_reg));

    assign need       = NEED_W'(need_words_reg) << WORD_SHIFT;
    assign total_ext  = CMP_W'(total_reg);
    assign need_ext   = $signed(CMP_W'(need));
    assign fits       = (op_reg == REQ_ALLOC) && (total_ext >= need_ext);
    assign do_split   = total_ext > (need_ext + CMP_W'(WORD_BYTES));
    assign merge_more = !flags.at_end && flags.is_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en) begin
                    state_next = cfg_small ? ST_IDLE : ST_BUILD_HEAD;
                end else if (accept) begin
                    unique case (req_type)
                        REQ_ALLOC: begin
                            state_next = (!ready_reg || size_bytes == '0) ? ST_DONE
                                                                          : ST_WALK_CUR;
                        end
                        REQ_FREE: begin
                            state_next = (block_offset != '0 && ready_reg && free_in_pool)
                                       ? ST_FREE_WR : ST_DONE;
                        end
                        REQ_QUERY: begin
                            state_next = ready_reg ? ST_WALK_CUR : ST_DONE;
                        end
                        REQ_NOP: begin
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_BUILD_HEAD: state_next = ST_BUILD_END;
            ST_BUILD_END:  state_next = ST_IDLE;
            ST_WALK_CUR: begin
                if (flags.at_end) begin
                    state_next = ST_DONE;
                end else if (flags.is_free) begin
                    state_next = ST_WALK_MERGE;
                end
            end
            ST_WALK_MERGE: begin
                if (!merge_more) begin
                    if (fits) begin
                        state_next = do_split ? ST_SPLIT : ST_DONE;
                    end else begin
                        state_next = ST_WALK_CUR;
                    end
                end
            end
            ST_SPLIT:   state_next = ST_DONE;
            ST_FREE_WR: state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        ready_next      = ready_reg;
        end_word_next   = end_word_reg;
        op_next         = op_reg;
        need_words_next = need_words_reg;
        cur_next        = cur_reg;
        total_next      = total_reg;
        largest_next    = largest_reg;
        res_next        = res_reg;
        split_addr_next = split_addr_reg;
        split_val_next  = split_val_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en) begin
                    ready_next    = !cfg_small;
                    end_word_next = cfg_small ? '0 : AW'(cfg_words_sat - 32'd1);
                end else if (accept) begin
                    res_next        = '{status: STAT_OK, alloc_offset: '0, largest_bytes: '0};
                    op_next         = req_type;
                    need_words_next = NWD_W'((32'(size_bytes) + 32'(WORD_BYTES - 1))
                                             >> WORD_SHIFT);
                    cur_next        = '0;
                    largest_next    = '0;
                    unique case (req_type)
                        REQ_ALLOC: begin
                            if (!ready_reg) begin
                                res_next.status = STAT_NO_POOL;
                            end else if (size_bytes == '0) begin
                                res_next.status = STAT_NO_FIT;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        REQ_FREE: begin
                            if (block_offset == '0) begin
                                res_next.status = STAT_NULL_FREE;
                            end else if (!ready_reg) begin
                                res_next.status = STAT_NO_POOL;
                            end else if (free_in_pool) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(32'(off_words) - 32'd1);
                            end
                        end
                        REQ_QUERY: begin
                            if (!ready_reg) begin
                                res_next.status = STAT_NO_POOL;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        REQ_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BUILD_HEAD: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = HDR_W'((32'(end_word_reg) - 32'd1) << WORD_SHIFT);
            end
            ST_BUILD_END: begin
                wr_en   = 1'b1;
                wr_addr = end_word_reg;
                wr_data = '0;
            end
            ST_WALK_CUR: begin
                if (flags.at_end) begin
                    res_next.status        = (op_reg == REQ_ALLOC) ? STAT_NO_FIT : STAT_OK;
                    res_next.largest_bytes = (op_reg == REQ_QUERY) ? largest_reg : '0;
                end else begin
                    // a block not at the end never reaches past the end marker
                    rd_en   = 1'b1;
                    rd_addr = AW'(nxt);
                    if (flags.is_free) begin
                        total_next = rd_data;
                    end else begin
                        cur_next = AW'(nxt);
                    end
                end
            end
            ST_WALK_MERGE: begin
                if (merge_more) begin
                    total_next = total_reg + rd_data + HDR_W'(WORD_BYTES);
                    rd_en      = 1'b1;
                    rd_addr    = AW'(nxt);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    if (fits) begin
                        res_next.alloc_offset = OFF_W'((32'(cur_reg) + 32'd1) << WORD_SHIFT);
                        if (do_split) begin
                            wr_data         = -HDR_W'(need);
                            split_addr_next = AW'(32'(cur_reg) + 32'd1 + 32'(need_words_reg));
                            split_val_next  = total_reg - HDR_W'(need) - HDR_W'(WORD_BYTES);
                        end else begin
                            wr_data = -total_reg;
                        end
                    end else begin
                        wr_data = total_reg;
                        if (op_reg == REQ_QUERY && OFF_W'(total_reg) > largest_reg) begin
                            largest_next = OFF_W'(total_reg);
                        end
                        // re-read the block that stopped the merge as the new current one
                        cur_next = data_addr_reg;
                        rd_en    = 1'b1;
                        rd_addr  = data_addr_reg;
                    end
                end
            end
            ST_SPLIT: begin
                wr_en   = 1'b1;
                wr_addr = split_addr_reg;
                wr_data = split_val_reg;
            end
            ST_FREE_WR: begin
                wr_en   = 1'b1;
                wr_addr = data_addr_reg;
                wr_data = (rd_data < 0) ? -rd_data : rd_data;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ready_reg    <= 1'b0;
            end_word_reg <= '0;
        end else begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            end_word_reg <= end_word_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        need_words_reg <= need_words_next;
        cur_reg        <= cur_next;
        total_reg      <= total_next;
        largest_reg    <= largest_next;
        res_reg        <= res_next;
        split_addr_reg <= split_addr_next;
        split_val_reg  <= split_val_next;
        if (rd_en) begin
            data_addr_reg <= rd_addr;
        end
    end

endmodule

### test/first_fit_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_tb - self-checking bench for the allocator
// Drives allocate, free, query and no-op requests over a range of pool sizes.
// A predictor keeps its own header table and checks every response in order.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit_tb;
    import ffa_pkg::*;

    localparam int          POOL_BYTES   = POOL_WORDS_DEF * WORD_BYTES;
    localparam int          OFF_MAX      = (1 << OFF_W) - 1;
    localparam int unsigned CYCLE_LIMIT  = 20000000;
    localparam int          CFG_GAP      = 4;
    localparam int          DRAIN_CYCLES = 20;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata     = '0;   // size_bytes[15:0], block_offset[29:16]
    logic [1:0]         s_tuser     = '0;   // req_type[1:0]
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [31:0]        m_tdata;            // alloc_offset[13:0], largest_bytes[27:14]
    logic [1:0]         m_tuser;            // status[1:0]
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;

    // predictor state
    int                 hdr [POOL_WORDS_DEF];
    logic [CFG_W-1:0]   pool_cfg;
    bit                 pool_built = 1'b0;
    int unsigned        end_idx = 0;

    res_t               pending_responses [$];
    logic [OFF_W-1:0]   live_blocks [$];
    logic [OFF_W-1:0]   granted_log [$];

    bit                 steady = 1'b0;
    int unsigned        cycle_count = 0;
    int                 failures = 0;
    int                 n_requests = 0;
    int                 n_grants = 0;
    int                 n_no_fit = 0;
    int                 n_queries = 0;
    int                 n_pool_writes = 0;

    first_fit_block_allocator_unit #(
        .POOL_WORDS (POOL_WORDS_DEF)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_responses.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic int unsigned blk_words(int v);
        return (v < 0 ? -v : v) / WORD_BYTES;
    endfunction

    function automatic int unsigned next_block(int unsigned i);
        return i + 1 + blk_words(hdr[i]);
    endfunction

    // end marker, zero header or a block running past the end stops a walk
    function automatic bit chain_end(int unsigned i);
        if (i >= end_idx) return 1'b1;
        if (hdr[i] == 0) return 1'b1;
        return next_block(i) > end_idx;
    endfunction

    function automatic void coalesce(int unsigned i);
        int unsigned j;
        int total;
        if (chain_end(i) || hdr[i] <= 0) return;
        total = hdr[i];
        j = next_block(i);
        while (!chain_end(j) && hdr[j] > 0) begin
            total += hdr[j] + WORD_BYTES;
            j = next_block(j);
        end
        hdr[i] = total;
    endfunction

    function automatic void apply_pool_size(logic [CFG_W-1:0] v);
        int unsigned eff;
        pool_cfg = v;
        eff = (v > POOL_BYTES) ? POOL_BYTES : v;
        if (eff < 3 * WORD_BYTES) begin
            pool_built = 1'b0;
            end_idx = 0;
            return;
        end
        end_idx = eff / WORD_BYTES - 1;
        hdr[0] = (end_idx - 1) * WORD_BYTES;
        hdr[end_idx] = 0;
        pool_built = 1'b1;
    endfunction

    function automatic res_t pool_response(req_t r, logic [SIZE_W-1:0] sz,
                                           logic [OFF_W-1:0] off);
        res_t res;
        int unsigned need, i, k, biggest;
        int blk;
        res = '0;
        res.status = STAT_OK;
        biggest = 0;
        case (r)
            REQ_ALLOC: begin
                if (!pool_built) begin
                    res.status = STAT_NO_POOL;
                end else if (sz == 0) begin
                    res.status = STAT_NO_FIT;
                end else begin
                    need = ((int'(sz) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
                    i = 0;
                    coalesce(0);
                    while (!chain_end(i) && hdr[i] < int'(need)) begin
                        i = next_block(i);
                        coalesce(i);
                    end
                    if (chain_end(i)) begin
                        res.status = STAT_NO_FIT;
                    end else begin
                        blk = hdr[i];
                        // split only when the leftover is more than a header
                        if (blk > int'(need) + WORD_BYTES) begin
                            hdr[i] = -int'(need);
                            hdr[i + 1 + need / WORD_BYTES] = blk - int'(need) - WORD_BYTES;
                        end else begin
                            hdr[i] = -blk;
                        end
                        res.alloc_offset = OFF_W'((i + 1) * WORD_BYTES);
                    end
                end
            end
            REQ_FREE: begin
                if (off == 0) begin
                    res.status = STAT_NULL_FREE;
                end else if (!pool_built) begin
                    res.status = STAT_NO_POOL;
                end else if (off % WORD_BYTES == 0) begin
                    k = off / WORD_BYTES - 1;
                    if (k < end_idx) hdr[k] = (hdr[k] < 0) ? -hdr[k] : hdr[k];
                end
            end
            REQ_QUERY: begin
                if (!pool_built) begin
                    res.status = STAT_NO_POOL;
                end else begin
                    i = 0;
                    while (!chain_end(i)) begin
                        coalesce(i);
                        if (hdr[i] > 0 && hdr[i] > biggest) biggest = hdr[i];
                        i = next_block(i);
                    end
                    res.largest_bytes = OFF_W'(biggest);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- response checker ----------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_response();
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
    end

    function automatic void check_response();
        res_t want;
        if (pending_responses.size() == 0) begin
            $error("unexpected response: status %0d data %h", m_tuser, m_tdata);
            failures++;
            return;
        end
        want = pending_responses.pop_front();
        if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            failures++;
        end
        if (m_tdata[OFF_W-1:0] !== want.alloc_offset) begin
            $error("alloc_offset: expected %0d, got %0d",
                   want.alloc_offset, m_tdata[OFF_W-1:0]);
            failures++;
        end
        if (m_tdata[2*OFF_W-1:OFF_W] !== want.largest_bytes) begin
            $error("largest_bytes: expected %0d, got %0d",
                   want.largest_bytes, m_tdata[2*OFF_W-1:OFF_W]);
            failures++;
        end
    endfunction

    // ---------------- stimulus ----------------

    // valid stays high between back-to-back transactions
    task automatic send_request(input req_t r, input logic [SIZE_W-1:0] sz,
                                input logic [OFF_W-1:0] off);
        res_t want;
        if (!steady) begin
            while ($urandom_range(99) < 26) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r;
        s_tdata  <= {2'b00, off, sz};
        do @(posedge aclk); while (!s_tready);
        want = pool_response(r, sz, off);
        pending_responses.push_back(want);
        n_requests++;
        if (r == REQ_QUERY) n_queries++;
        if (r == REQ_ALLOC && want.status == STAT_OK) begin
            n_grants++;
            live_blocks.push_back(want.alloc_offset);
            granted_log.push_back(want.alloc_offset);
        end
        if (r == REQ_ALLOC && want.status == STAT_NO_FIT) n_no_fit++;
    endtask

    // only with the block idle: all responses in and a few quiet cycles
    task automatic write_pool_size(input logic [CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (CFG_GAP) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        apply_pool_size(v);
        n_pool_writes++;
        live_blocks.delete();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] random_alloc_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return SIZE_W'($urandom_range(64, 1));
        if (roll < 90) return SIZE_W'($urandom_range(512, 65));
        if (roll < 97) return SIZE_W'($urandom_range(POOL_BYTES, 1));
        return SIZE_W'($urandom);
    endfunction

    task automatic run_traffic(input int count);
        int unsigned pick, idx;
        logic [OFF_W-1:0] off;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 32 && live_blocks.size() != 0) begin
                idx = $urandom_range(live_blocks.size() - 1);
                off = live_blocks[idx];
                live_blocks.delete(idx);
                send_request(REQ_FREE, SIZE_W'($urandom), off);
            end else if (pick < 80) begin
                send_request(REQ_ALLOC, random_alloc_size(), OFF_W'($urandom));
            end else if (pick < 87) begin
                send_request(REQ_QUERY, SIZE_W'($urandom), OFF_W'($urandom));
            end else if (pick < 92) begin
                // stale or repeated free of an offset granted earlier
                off = '0;
                if (granted_log.size() != 0)
                    off = granted_log[$urandom_range(granted_log.size() - 1)];
                send_request(REQ_FREE, SIZE_W'($urandom), off);
            end else if (pick < 96) begin
                case ($urandom_range(2))
                    0: off = '0;
                    1: begin
                        off = OFF_W'($urandom);
                        off[WORD_SHIFT-1:0] = WORD_SHIFT'($urandom_range(WORD_BYTES - 1, 1));
                    end
                    default: begin
                        off = OFF_W'($urandom_range(OFF_MAX, (end_idx + 1) * WORD_BYTES));
                        off[WORD_SHIFT-1:0] = '0;
                    end
                endcase
                send_request(REQ_FREE, SIZE_W'($urandom), off);
            end else if (pick < 98) begin
                send_request(REQ_NOP, SIZE_W'($urandom), OFF_W'($urandom));
            end else begin
                send_request(REQ_ALLOC, '0, OFF_W'($urandom));
            end
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_unbuilt_pool();
        send_request(REQ_ALLOC, 16'd8, '0);
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_FREE, '0, 14'd8);
        send_request(REQ_QUERY, '0, '0);
        send_request(REQ_NOP, '1, '1);
    endtask

    // five-word pool: exact fit, split, merge on query and the ignored frees
    task automatic test_fit_and_split();
        write_pool_size(14'd40);
        send_request(REQ_ALLOC, 16'd16, '0);
        send_request(REQ_ALLOC, 16'd8, '0);
        send_request(REQ_FREE, '0, 14'd8);
        send_request(REQ_ALLOC, 16'd8, '0);
        send_request(REQ_ALLOC, 16'd8, '0);
        send_request(REQ_FREE, '0, 14'd8);
        send_request(REQ_FREE, '0, 14'd24);
        send_request(REQ_QUERY, '0, '0);
        send_request(REQ_FREE, '0, 14'd13);
        send_request(REQ_FREE, '0, 14'd16376);
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_ALLOC, 16'hFFFF, '0);
        send_request(REQ_ALLOC, '0, '0);
    endtask

    task automatic test_pool_limits();
        write_pool_size('1);                    // clamps to the full pool
        send_request(REQ_ALLOC, 16'(POOL_BYTES - 2 * WORD_BYTES), '0);
        send_request(REQ_QUERY, '0, '0);
        send_request(REQ_FREE, '0, 14'd8);
        send_request(REQ_QUERY, '0, '0);
        write_pool_size(14'(3 * WORD_BYTES - 1));
        send_request(REQ_ALLOC, 16'd1, '0);
        write_pool_size(14'(3 * WORD_BYTES));
        send_request(REQ_ALLOC, 16'd1, '0);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] pool;
        int items;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       begin pool = 14'd8192;  items = 100; end
                1:       begin pool = 14'd1000;  items = 100; end
                2:       begin pool = 14'd24;    items = 30;  end
                3:       begin pool = '1;        items = 120; end
                4:       begin pool = 14'd512;   items = 100; end
                5:       begin pool = '0;        items = 20;  end
                6:       begin pool = 14'd4096;  items = 90;  end
                default: begin
                    pool = CFG_W'($urandom_range(POOL_BYTES, 3 * WORD_BYTES));
                    items = 90;
                end
            endcase
            write_pool_size(pool);
            steady = (p == 3);      // one long run without any idle cycles
            run_traffic(items);
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unbuilt_pool();
        test_fit_and_split();
        test_pool_limits();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d grants, %0d failed allocations, %0d queries",
                 n_requests, n_grants, n_no_fit, n_queries);
        $display("Pool size written %0d times, including unusable and clamped sizes",
                 n_pool_writes);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
